// File: rtl/desq_pkg.sv
// Package for the dual-ended shared queue: operation codes, field widths and
// default sizes. It depends on nothing and is imported by every RTL file of the block.
`default_nettype none

package desq_pkg;

	localparam int DepthDef    = 1024;
	localparam int WordBitsDef = 32;

	localparam int FuncW   = 3;
	localparam int PortWW  = 32;
	localparam int CountW  = 11;

	// Operation codes carried by func. Code 7 has no meaning and acts as a no-op.
	typedef enum logic [FuncW-1:0] {
		FN_PUSH_FWD     = 3'd0,
		FN_POP_FWD      = 3'd1,
		FN_POP_BACK_FWD = 3'd2,
		FN_PUSH_BWD     = 3'd3,
		FN_POP_BWD      = 3'd4,
		FN_POP_BACK_BWD = 3'd5,
		FN_CLEAR        = 3'd6
	} func_t;

	// Access request from the pointer logic to the word memory.
	typedef struct packed {
		logic we;
		logic re;
	} mem_req_t;

endpackage

`default_nettype wire

// File: rtl/desq_mem.sv
// Word memory of the dual-ended shared queue: one port, synchronous write,
// read data registered. Depends on desq_pkg.
`default_nettype none

module desq_mem
	import desq_pkg::*;
#(
	parameter int DEPTH     = DepthDef,
	parameter int WORD_BITS = WordBitsDef,
	localparam int AW       = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire mem_req_t             req,
	input  wire logic [AW-1:0]        addr,
	input  wire logic [WORD_BITS-1:0] wdata,
	output logic      [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	// Entries are never cleared; the queue logic reads only entries it has written.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/dual_ended_shared_queue_top.sv
// Top level of the dual-ended shared queue: pointer logic, result stage and the
// word memory (desq_mem). Depends on desq_pkg.
`default_nettype none

// Two queues share one memory of DEPTH words. The forward queue fills upwards from
// entry 0 and the backward queue fills downwards from the top entry. Each queue can
// be pushed, popped at its front (oldest item) or popped at its back (newest item,
// undoing the last push). Space freed by a front pop is only reclaimed by a clear;
// a back pop frees its entry at once. A push made when the two regions already meet
// is refused and reported in push_refused. A pop on an empty queue returns
// pop_valid low and pop_word zero. Every accepted item gives exactly one result,
// which also carries both counts and both empty flags after the operation.
// Timing: the result of an item is offered in the cycle after the item is
// accepted, and one item can be accepted every cycle. The pace is set by the
// single-port word memory: each item makes at most one access, and the registered
// read data forms the result stage together with the status registers. Input
// stall is high only while a result waits and the output side stalls. Stored words
// survive a clear and are not initialised after reset; there is no clearing pass.

module dual_ended_shared_queue_top
	import desq_pkg::*;
#(
	parameter int DEPTH     = DepthDef,
	parameter int WORD_BITS = WordBitsDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [FuncW-1:0]  func,
	input  wire logic [PortWW-1:0] push_word,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [PortWW-1:0] pop_word,
	output logic                   pop_valid,
	output logic                   push_refused,
	output logic      [CountW-1:0] fwd_count,
	output logic      [CountW-1:0] bwd_count,
	output logic                   fwd_empty,
	output logic                   bwd_empty
);

	localparam int AW    = $clog2(DEPTH);
	// Pointers need to hold DEPTH itself and, for the backward queue, one below
	// entry zero, which is kept as all ones.
	localparam int PTR_W = AW + 1;
	localparam logic [PTR_W-1:0] TopEntry = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PtrOne   = PTR_W'(1);

	// Queue pointers. The forward queue holds [fwd_front, fwd_back) and the
	// backward queue holds (bwd_back, bwd_front].
	logic [PTR_W-1:0] fwd_front_q, fwd_back_q, bwd_front_q, bwd_back_q;
	logic [PTR_W-1:0] fwd_front_n, fwd_back_n, bwd_front_n, bwd_back_n;

	// Result stage.
	logic              res_valid_s1;
	logic              pop_valid_s1;
	logic              refused_s1;
	logic [CountW-1:0] fcnt_s1, bcnt_s1;
	logic              fempty_s1, bempty_s1;

	logic             accept;
	logic             no_room, f_empty, b_empty;
	logic             pop_hit, push_ref;
	logic             do_write, do_read;
	logic [AW-1:0]    mem_addr;
	mem_req_t         mem_req;
	logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
	logic [63:0]      push_ext, pop_ext;
	logic [PTR_W-1:0] fcnt_n, bcnt_n;
	logic [PTR_W-1:0] cur_fcnt, cur_bcnt;
	logic [PTR_W+CountW-1:0] fcnt_ext, bcnt_ext;

	// A new item may enter whenever the result stage is empty or is being taken.
	assign in_stall = res_valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	// Free entries are fwd_back .. bwd_back; none are left when they cross.
	assign no_room = (fwd_back_q == bwd_back_q + PtrOne);
	assign f_empty = (fwd_front_q == fwd_back_q);
	assign b_empty = (bwd_front_q == bwd_back_q);

	always_comb begin
		fwd_front_n = fwd_front_q;
		fwd_back_n  = fwd_back_q;
		bwd_front_n = bwd_front_q;
		bwd_back_n  = bwd_back_q;
		do_write    = 1'b0;
		do_read     = 1'b0;
		pop_hit     = 1'b0;
		push_ref    = 1'b0;
		mem_addr    = '0;
		unique case (func)
			FN_PUSH_FWD: begin
				if (no_room) begin
					push_ref = 1'b1;
				end else begin
					do_write   = 1'b1;
					mem_addr   = fwd_back_q[AW-1:0];
					fwd_back_n = fwd_back_q + PtrOne;
				end
			end
			FN_POP_FWD: begin
				if (!f_empty) begin
					do_read     = 1'b1;
					pop_hit     = 1'b1;
					mem_addr    = fwd_front_q[AW-1:0];
					fwd_front_n = fwd_front_q + PtrOne;
				end
			end
			FN_POP_BACK_FWD: begin
				if (!f_empty) begin
					do_read    = 1'b1;
					pop_hit    = 1'b1;
					fwd_back_n = fwd_back_q - PtrOne;
					mem_addr   = fwd_back_n[AW-1:0];
				end
			end
			FN_PUSH_BWD: begin
				if (no_room) begin
					push_ref = 1'b1;
				end else begin
					do_write   = 1'b1;
					mem_addr   = bwd_back_q[AW-1:0];
					bwd_back_n = bwd_back_q - PtrOne;
				end
			end
			FN_POP_BWD: begin
				if (!b_empty) begin
					do_read     = 1'b1;
					pop_hit     = 1'b1;
					mem_addr    = bwd_front_q[AW-1:0];
					bwd_front_n = bwd_front_q - PtrOne;
				end
			end
			FN_POP_BACK_BWD: begin
				if (!b_empty) begin
					do_read    = 1'b1;
					pop_hit    = 1'b1;
					bwd_back_n = bwd_back_q + PtrOne;
					mem_addr   = bwd_back_n[AW-1:0];
				end
			end
			FN_CLEAR: begin
				fwd_front_n = '0;
				fwd_back_n  = '0;
				bwd_front_n = TopEntry;
				bwd_back_n  = TopEntry;
			end
			default: begin
			end
		endcase
	end

	// Counts after the operation; differences wrap in the pointer width, which
	// is exact since real counts never exceed DEPTH.
	assign fcnt_n   = fwd_back_n - fwd_front_n;
	assign bcnt_n   = bwd_front_n - bwd_back_n;
	assign fcnt_ext = (PTR_W + CountW)'(fcnt_n);
	assign bcnt_ext = (PTR_W + CountW)'(bcnt_n);

	assign push_ext  = 64'(push_word);
	assign mem_wdata = push_ext[WORD_BITS-1:0];
	assign mem_req   = '{we: accept && do_write, re: accept && do_read};

	desq_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_front_q  <= '0;
			fwd_back_q   <= '0;
			bwd_front_q  <= TopEntry;
			bwd_back_q   <= TopEntry;
			res_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fwd_front_q  <= fwd_front_n;
				fwd_back_q   <= fwd_back_n;
				bwd_front_q  <= bwd_front_n;
				bwd_back_q   <= bwd_back_n;
				res_valid_s1 <= 1'b1;
			end else if (!out_stall) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	// Status of the item travels beside the memory read and meets its data here.
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_valid_s1 <= pop_hit;
			refused_s1   <= push_ref;
			fcnt_s1      <= fcnt_ext[CountW-1:0];
			bcnt_s1      <= bcnt_ext[CountW-1:0];
			fempty_s1    <= (fcnt_n == '0);
			bempty_s1    <= (bcnt_n == '0);
		end
	end

	assign pop_ext      = 64'(mem_rdata);
	assign out_valid    = res_valid_s1;
	assign pop_word     = pop_valid_s1 ? pop_ext[PortWW-1:0] : '0;
	assign pop_valid    = pop_valid_s1;
	assign push_refused = refused_s1;
	assign fwd_count    = fcnt_s1;
	assign bwd_count    = bcnt_s1;
	assign fwd_empty    = fempty_s1;
	assign bwd_empty    = bempty_s1;

	// The two regions together never claim more entries than the memory has.
	assign cur_fcnt = fwd_back_q - fwd_front_q;
	assign cur_bcnt = bwd_front_q - bwd_back_q;

	a_regions_fit: assert property (@(posedge clk) disable iff (!arst_n)
		((PTR_W + 1)'(cur_fcnt) + (PTR_W + 1)'(cur_bcnt)) <= (PTR_W + 1)'(DEPTH))
		else $error("queue regions overlap");

	a_pop_or_push: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s1 && pop_valid_s1) |-> !refused_s1)
		else $error("result both popped and refused a push");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FN_CLEAR) |=> (res_valid_s1 && fempty_s1 && bempty_s1))
		else $error("clear did not empty both queues");

	// Space left behind by front pops stays claimed, so a refusal can come with
	// counts below DEPTH; it only ever comes from a push when the regions meet.
	a_refuse_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_ref) |-> (no_room && (func == FN_PUSH_FWD || func == FN_PUSH_BWD)))
		else $error("push refused while free entries remain");

endmodule

`default_nettype wire
